// ----- src/deq_pkg.sv -----
// Package for the double-ended queue: sizes, request and status codes,
// sequencer states and the command and status bundles between controller and datapath.
// No dependencies.
package deq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2,
    ST_UNUSED     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CAPTURE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
  } deq_cmd_t;

  typedef struct packed {
    logic out_free;
  } deq_sts_t;

endpackage

// ----- src/deq_if.sv -----
// Channel interfaces for the double-ended queue: request and response.
// Depends on deq_pkg.
interface deq_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic signed [31:0]  push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  pop_value;
  logic [1:0]          status;
  logic [6:0]          item_count;
  logic                is_empty;

  modport source (output valid, output pop_value, output status, output item_count,
                  output is_empty, input ready);
  modport sink   (input valid, input pop_value, input status, input item_count,
                  input is_empty, output ready);
endinterface

// ----- src/deq_ctrl.sv -----
// Sequencer of the double-ended queue: accept, execute, capture the result.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_sts_t sts,
  output deq_pkg::deq_cmd_t cmd
);

  deq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::S_IDLE: begin
        if (in_valid) state_next = deq_pkg::S_EXEC;
      end
      deq_pkg::S_EXEC: begin
        state_next = deq_pkg::S_CAPTURE;
      end
      deq_pkg::S_CAPTURE: begin
        if (sts.out_free) state_next = deq_pkg::S_IDLE;
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      deq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      deq_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      deq_pkg::S_CAPTURE: begin
        cmd.capture = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/deq_dpath.sv -----
// Datapath of the double-ended queue: ring store, indices, count and result register.
// Depends on deq_pkg.
module deq_dpath (
  input  logic              clk,
  input  logic              rst,
  input  deq_pkg::deq_cmd_t cmd,
  output deq_pkg::deq_sts_t sts,
  input  logic [1:0]        in_req_type,
  input  logic signed [31:0] in_push_value,
  input  logic              out_ready,
  output logic              out_valid,
  output logic signed [31:0] out_pop_value,
  output logic [1:0]        out_status,
  output logic [6:0]        out_item_count,
  output logic              out_is_empty
);

  deq_pkg::word_t   mem [deq_pkg::DEPTH];
  deq_pkg::word_t   rd_data;

  deq_pkg::req_t    req;
  deq_pkg::word_t   value;
  deq_pkg::idx_t    front_index, back_index;
  deq_pkg::cnt_t    word_count;
  deq_pkg::status_t res_status;
  logic             pop_ok;

  logic             is_full, is_zero, is_push;
  logic             we, re;
  deq_pkg::idx_t    waddr, raddr;
  deq_pkg::idx_t    front_next, back_next;
  deq_pkg::cnt_t    count_next;
  deq_pkg::status_t status_next;

  assign is_full = (word_count == deq_pkg::cnt_t'(deq_pkg::DEPTH));
  assign is_zero = (word_count == '0);
  assign is_push = (req == deq_pkg::REQ_PUSH_BACK) || (req == deq_pkg::REQ_PUSH_FRONT);

  always_comb begin
    we          = 1'b0;
    re          = 1'b0;
    waddr       = back_index;
    raddr       = front_index;
    front_next  = front_index;
    back_next   = back_index;
    count_next  = word_count;
    status_next = deq_pkg::ST_OK;
    if (is_push && is_full) begin
      status_next = deq_pkg::ST_PUSH_FULL;
    end else if (!is_push && is_zero) begin
      status_next = deq_pkg::ST_POP_EMPTY;
    end else begin
      unique case (req)
        deq_pkg::REQ_PUSH_BACK: begin
          we         = 1'b1;
          waddr      = back_index;
          back_next  = back_index + 1'b1;
          count_next = word_count + 1'b1;
        end
        deq_pkg::REQ_PUSH_FRONT: begin
          we         = 1'b1;
          waddr      = front_index - 1'b1;
          front_next = front_index - 1'b1;
          count_next = word_count + 1'b1;
        end
        deq_pkg::REQ_POP_FRONT: begin
          re         = 1'b1;
          raddr      = front_index;
          front_next = front_index + 1'b1;
          count_next = word_count - 1'b1;
        end
        deq_pkg::REQ_POP_BACK: begin
          re         = 1'b1;
          raddr      = back_index - 1'b1;
          back_next  = back_index - 1'b1;
          count_next = word_count - 1'b1;
        end
        default: begin
          re = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[waddr] <= value;
    if (cmd.exec && re) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= deq_pkg::req_t'(in_req_type);
      value <= deq_pkg::word_t'(in_push_value);
    end
    if (cmd.exec) begin
      res_status <= status_next;
      pop_ok     <= !is_push && (status_next == deq_pkg::ST_OK);
    end
    if (cmd.capture) begin
      out_pop_value  <= pop_ok ? 32'(rd_data) : '0;
      out_status     <= res_status;
      out_item_count <= 7'(word_count);
      out_is_empty   <= is_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      word_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        front_index <= front_next;
        back_index  <= back_next;
        word_count  <= count_next;
      end
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

// ----- src/double_ended_queue.sv -----
// A bounded double-ended queue of 64 signed 32-bit words in a ring store. Each request
// transaction pushes at the back or front or pops the front or back, and yields exactly
// one response transaction with the popped word, a status, the count and an empty flag.
// A request passes through accept, execute with the store access and capture of the
// registered read into the output register; no new request is taken until the last one
// is captured. A waiting response holds off the capture of the next one and, with it,
// the acceptance of any further request. The store needs no clearing pass after reset.
// Depends on deq_pkg, deq_if, deq_ctrl and deq_dpath.
module double_ended_queue (
  input  logic clk,
  input  logic rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  deq_pkg::deq_cmd_t cmd;
  deq_pkg::deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  deq_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (req.req_type),
    .in_push_value  (req.push_value),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_pop_value  (rsp.pop_value),
    .out_status     (rsp.status),
    .out_item_count (rsp.item_count),
    .out_is_empty   (rsp.is_empty)
  );

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.item_count == 7'd0)))
    else $error("Empty flag disagrees with the count.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != deq_pkg::ST_OK) |-> (rsp.pop_value == 32'sd0))
    else $error("Failed request returned a nonzero word.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.item_count <= 7'(deq_pkg::DEPTH)))
    else $error("Count exceeds the store depth.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("Request taken while one is in progress.");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for double_ended_queue: directed and random request transactions, responses
// checked field by field against an in-bench ring-buffer deque predictor.
// Depends on deq_pkg, deq_if and the double_ended_queue RTL.
module tb_top;
  import deq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL     = 120;
  localparam int MAX_LINES      = 40;

  typedef struct {
    word_t   pop_value;
    status_t status;
    cnt_t    item_count;
    logic    is_empty;
  } deq_result_t;

  logic clk;
  logic rst;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  word_t       ring [DEPTH];
  idx_t        front_ptr;
  idx_t        back_ptr;
  cnt_t        held;
  deq_result_t pending_results [$];

  int mismatch_count;
  int idle_cycles;
  bit steady_flow;
  bit hold_responses;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic idx_t next_slot(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic idx_t prev_slot(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic void predict_deque(req_t op, word_t value);
    deq_result_t r;
    r.pop_value = '0;
    r.status    = ST_OK;
    if (op == REQ_PUSH_BACK || op == REQ_PUSH_FRONT) begin
      if (held == cnt_t'(DEPTH)) begin
        r.status = ST_PUSH_FULL;
      end else if (op == REQ_PUSH_BACK) begin
        ring[back_ptr] = value;
        back_ptr = next_slot(back_ptr);
        held++;
      end else begin
        front_ptr = prev_slot(front_ptr);
        ring[front_ptr] = value;
        held++;
      end
    end else begin
      if (held == '0) begin
        r.status = ST_POP_EMPTY;
      end else if (op == REQ_POP_FRONT) begin
        r.pop_value = ring[front_ptr];
        front_ptr = next_slot(front_ptr);
        held--;
      end else begin
        back_ptr = prev_slot(back_ptr);
        r.pop_value = ring[back_ptr];
        held--;
      end
    end
    r.item_count = held;
    r.is_empty   = (held == '0);
    pending_results.push_back(r);
  endfunction

  function automatic word_t draw_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_LINES) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic send_request(req_t op, word_t value);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= op;
    req_ch.push_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_deque(op, value);
  endtask

  task automatic test_empty_pops();
    send_request(REQ_POP_FRONT, 32'h1234_5678);
    send_request(REQ_POP_BACK, '1);
  endtask

  task automatic test_extremes_and_wrap();
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, '0);
    send_request(REQ_PUSH_BACK, '1);
    send_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(REQ_PUSH_BACK, 32'h5555_5555);
    repeat (3) send_request(REQ_POP_BACK, '0);
    repeat (3) send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '0);
  endtask

  task automatic test_single_word();
    send_request(REQ_PUSH_BACK, 32'h0000_0001);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFE);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_PUSH_FRONT, 32'h0F0F_0F0F);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_PUSH_BACK, 32'hF0F0_F0F0);
    send_request(REQ_POP_BACK, '0);
  endtask

  task automatic test_fill_and_overflow();
    while (held != cnt_t'(DEPTH))
      send_request(req_t'($urandom_range(0, 1)), draw_word());
    send_request(REQ_PUSH_BACK, draw_word());
    send_request(REQ_PUSH_FRONT, draw_word());
    while (held != '0)
      send_request(req_t'($urandom_range(2, 3)), draw_word());
    send_request(REQ_POP_FRONT, draw_word());
  endtask

  task automatic test_backpressure();
    steady_flow    = 1'b1;
    hold_responses = 1'b1;
    repeat (40) send_request(req_t'($urandom_range(0, 3)), draw_word());
    steady_flow = 1'b0;
  endtask

  task automatic test_random_mix();
    int push_pct;
    req_t op;
    for (int blk = 0; blk < 15; blk++) begin
      push_pct    = (blk % 4 == 3) ? 50 : ((blk % 2 == 0) ? 80 : 20);
      steady_flow = (blk % 5 == 2);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 99) < push_pct) op = req_t'($urandom_range(0, 1));
        else op = req_t'($urandom_range(2, 3));
        send_request(op, draw_word());
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin : stimulus
    mismatch_count     = 0;
    steady_flow        = 1'b0;
    hold_responses     = 1'b0;
    front_ptr          = '0;
    back_ptr           = '0;
    held               = '0;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_PUSH_BACK;
    req_ch.push_value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_pops();
    test_extremes_and_wrap();
    test_single_word();
    test_fill_and_overflow();
    test_backpressure();
    test_random_mix();

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : response_sink
    int gap;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_responses) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_responses = 1'b0;
      end
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : response_check
    deq_result_t exp_r;
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response transaction with no request outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_ch.pop_value !== exp_r.pop_value)
          report_mismatch($sformatf("pop_value got %0d, want %0d",
                                    rsp_ch.pop_value, exp_r.pop_value));
        if (rsp_ch.status !== exp_r.status)
          report_mismatch($sformatf("status got %0d, want %0d",
                                    rsp_ch.status, exp_r.status));
        if (rsp_ch.item_count !== exp_r.item_count)
          report_mismatch($sformatf("item_count got %0d, want %0d",
                                    rsp_ch.item_count, exp_r.item_count));
        if (rsp_ch.is_empty !== exp_r.is_empty)
          report_mismatch($sformatf("is_empty got %0b, want %0b",
                                    rsp_ch.is_empty, exp_r.is_empty));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
